### rtl/lps_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the linear prime sieve
// no dependencies

package lps_pkg;

  localparam int SIEVE_SIZE  = 65536;
  localparam int PRIME_SLOTS = 8192;

  localparam int CAND_W  = 16;
  localparam int TOTAL_W = 14;
  localparam int EXP_W   = CAND_W + 1;
  localparam int PROD_W  = 2 * CAND_W;

  localparam int FLAG_AW = $clog2(SIEVE_SIZE);
  localparam int LIST_AW = $clog2(PRIME_SLOTS);
  localparam int CNT_W   = $clog2(PRIME_SLOTS + 1);

  localparam int CAND_MAX = 2 ** CAND_W - 1;
  localparam logic [CAND_W-1:0] LIMIT_CAP =
    CAND_W'((SIEVE_SIZE - 1 > CAND_MAX) ? CAND_MAX : SIEVE_SIZE - 1);
  localparam logic [CAND_W-1:0] LIMIT_RESET = CAND_W'(CAND_MAX);
  localparam logic [EXP_W-1:0]  FIRST_CAND  = EXP_W'(2);

  typedef struct packed {
    logic               rd;
    logic               wr;
    logic [FLAG_AW-1:0] addr;
  } flag_req_t;

  typedef struct packed {
    logic              start;
    logic [CAND_W-1:0] dividend;
    logic [CAND_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic done;
    logic is_zero;
  } rem_rsp_t;

endpackage

### rtl/lps_ifs.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces: candidate in, result out, limit write
// depends on lps_pkg

interface lps_in_if import lps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CAND_W-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface lps_out_if import lps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               is_prime;
  logic [TOTAL_W-1:0] prime_total;
  logic               order_error;

  modport source (output valid, output is_prime, output prime_total, output order_error,
                  input ready);
  modport sink   (input valid, input is_prime, input prime_total, input order_error,
                  output ready);
endinterface

interface lps_cfg_if import lps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CAND_W-1:0] sieve_limit;

  modport source (output valid, output sieve_limit, input ready);
  modport sink   (input valid, input sieve_limit, output ready);
endinterface

### rtl/lps_flag_store.sv
`timescale 1ns / 1ps
// composite bitmap memory, one bit per number, with a clearing sweep after reset
// depends on lps_pkg

module lps_flag_store import lps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  flag_req_t req,
  output logic      rdata,
  output logic      clear_done
);

  logic               flags [SIEVE_SIZE];
  logic               clearing;
  logic [FLAG_AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == FLAG_AW'(SIEVE_SIZE - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + FLAG_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      flags[clr_addr] <= 1'b0;
    end else if (req.wr) begin
      flags[req.addr] <= 1'b1;
    end
    if (req.rd) begin
      rdata <= flags[req.addr];
    end
  end

  assign clear_done = !clearing;

endmodule

### rtl/lps_rem_unit.sv
`timescale 1ns / 1ps
// serial restoring remainder unit, one quotient bit per cycle
// depends on lps_pkg

module lps_rem_unit import lps_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  rem_req_t req,
  output rem_rsp_t rsp
);

  localparam int STEP_W = $clog2(CAND_W + 1);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] steps;
  logic [CAND_W-1:0] rem;
  logic [CAND_W-1:0] quo;
  logic [CAND_W-1:0] div;
  logic [CAND_W:0]   trial;
  logic [CAND_W:0]   diff;
  logic [CAND_W-1:0] rem_next;

  assign trial    = {rem, quo[CAND_W-1]};
  assign diff     = trial - {1'b0, div};
  assign rem_next = (trial >= {1'b0, div}) ? diff[CAND_W-1:0] : trial[CAND_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(CAND_W);
        rem   <= '0;
        quo   <= req.dividend;
        div   <= req.divisor;
      end else if (busy) begin
        rem   <= rem_next;
        quo   <= {quo[CAND_W-2:0], 1'b0};
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done    = done;
  assign rsp.is_zero = (rem == '0);

endmodule

### rtl/linear_prime_sieve_core.sv
`timescale 1ns / 1ps
// linear prime sieve: sequencer, prime list memory and result register
// depends on lps_pkg, lps_ifs, lps_flag_store, lps_rem_unit

// Candidates enter on in_ch (valid/ready) in ascending order from 2; each item
// gives one result on out_ch: is_prime, the running prime_total and order_error.
// An item out of sequence or above the limit returns order_error with no state
// change; it goes from S_IDLE through S_DONE into the output register. An
// accepted candidate reads its bit in the composite bitmap, appends itself to
// the prime list if clear, then walks the list marking candidate*p; each prime
// walked takes a list read, the product, the mark, then the serial remainder
// unit at one bit per cycle, and the walk goes at most up to the candidate's
// smallest prime factor. One item is in work at a time.
// cfg_ch writes sieve_limit (reset 65535) and is always ready; write it only
// while idle.
// After reset the bitmap is swept clear, one entry per cycle; in_ch.ready
// stays low until the sweep ends.
// The result sits in an output register; while the receiver stalls the next
// candidate can still be taken and worked, and its result waits until the
// register is free.

module linear_prime_sieve_core import lps_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  lps_in_if.sink        in_ch,
  lps_out_if.source     out_ch,
  lps_cfg_if.sink       cfg_ch
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FLAG  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]         state;
  logic [CAND_W-1:0]  sieve_limit;
  logic [CAND_W-1:0]  lim_eff;
  logic [CAND_W-1:0]  cand;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   idx;
  logic [EXP_W-1:0]   expected;
  logic [PROD_W-1:0]  prod;
  logic [CAND_W-1:0]  p_reg;
  logic               res_prime;
  logic               res_err;
  logic               out_valid;
  logic               out_prime;
  logic [TOTAL_W-1:0] out_total;
  logic               out_err;

  logic [CAND_W-1:0]  list_mem [PRIME_SLOTS];
  logic [CAND_W-1:0]  list_rdata;
  logic               list_we;
  logic               list_re;

  flag_req_t          flag_req;
  logic               flag_rdata;
  logic               clear_done;
  rem_req_t           rem_req;
  rem_rsp_t           rem_rsp;

  logic               accept;
  logic               cand_ok;
  logic               stop;
  logic               res_load;

  assign lim_eff = (sieve_limit > LIMIT_CAP) ? LIMIT_CAP : sieve_limit;

  assign in_ch.ready = (state == S_IDLE) && clear_done;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cand_ok     = ({1'b0, in_ch.candidate} == expected) &&
                       (in_ch.candidate <= lim_eff) &&
                       (in_ch.candidate >= CAND_W'(2));

  // walk ends on an empty entry or once the product passes the limit
  assign stop = (p_reg == '0) || (prod > PROD_W'(lim_eff));

  assign list_we = (state == S_FLAG) && !flag_rdata && (count < CNT_W'(PRIME_SLOTS));
  assign list_re = (state == S_SCAN) && (idx < count);

  // result register takes a new item when empty or being drained
  assign res_load = (state == S_DONE) && (!out_valid || out_ch.ready);

  always_comb begin
    flag_req.rd   = accept && cand_ok;
    flag_req.wr   = (state == S_CHECK) && !stop;
    flag_req.addr = (state == S_IDLE) ? FLAG_AW'(in_ch.candidate)
                                      : FLAG_AW'(prod[CAND_W-1:0]);
    rem_req.start    = (state == S_CHECK) && !stop;
    rem_req.dividend = cand;
    rem_req.divisor  = p_reg;
  end

  lps_flag_store u_flags (
    .clk        (clk),
    .rst        (rst),
    .req        (flag_req),
    .rdata      (flag_rdata),
    .clear_done (clear_done)
  );

  lps_rem_unit u_rem (
    .clk (clk),
    .rst (rst),
    .req (rem_req),
    .rsp (rem_rsp)
  );

  always_ff @(posedge clk) begin
    if (list_we) begin
      list_mem[count[LIST_AW-1:0]] <= cand;
    end
    if (list_re) begin
      list_rdata <= list_mem[idx[LIST_AW-1:0]];
    end
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sieve_limit <= LIMIT_RESET;
    end else if (cfg_ch.valid) begin
      sieve_limit <= cfg_ch.sieve_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      expected  <= FIRST_CAND;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cand <= in_ch.candidate;
            if (cand_ok) begin
              state <= S_FLAG;
            end else begin
              res_prime <= 1'b0;
              res_err   <= 1'b1;
              state     <= S_DONE;
            end
          end
        end
        S_FLAG: begin
          res_prime <= !flag_rdata;
          res_err   <= 1'b0;
          if (list_we) begin
            count <= count + CNT_W'(1);
          end
          expected <= {1'b0, cand} + EXP_W'(1);
          idx      <= '0;
          state    <= S_SCAN;
        end
        S_SCAN: begin
          state <= (idx < count) ? S_WAIT : S_DONE;
        end
        S_WAIT: begin
          prod  <= PROD_W'(cand) * PROD_W'(list_rdata);
          p_reg <= list_rdata;
          state <= S_CHECK;
        end
        S_CHECK: begin
          state <= stop ? S_DONE : S_DIV;
        end
        S_DIV: begin
          if (rem_rsp.done) begin
            if (rem_rsp.is_zero) begin
              state <= S_DONE;
            end else begin
              idx   <= idx + CNT_W'(1);
              state <= S_SCAN;
            end
          end
        end
        S_DONE: begin
          if (res_load) begin
            out_prime <= res_prime;
            out_total <= TOTAL_W'(count);
            out_err   <= res_err;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.is_prime    = out_prime;
  assign out_ch.prime_total = out_total;
  assign out_ch.order_error = out_err;

endmodule
